// ----- sv/psa_pkg.sv -----
package psa_pkg;

  // Sizing of the allocator
  localparam int PAGE_BYTES          = 4096;
  localparam int MAX_PAGES           = 16;
  localparam int CURSOR_DEPTH        = 32;
  localparam int CURSOR_RECORD_BYTES = 32;
  localparam int CURSOR_ALIGN_LOG2   = 3;

  // Word field widths
  localparam int CMD_W      = 3;
  localparam int SIZE_W     = 20;
  localparam int ALOG_W     = 4;
  localparam int CIDX_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int PAGE_OUT_W = 4;
  localparam int OFFSET_W   = 12;
  localparam int LIVE_W     = 6;
  localparam int BIG_W      = 16;

  // Internal widths
  localparam int OFF_W  = $clog2(PAGE_BYTES + 1);
  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int IDX_W  = $clog2(CURSOR_DEPTH);
  localparam int CNT_W  = $clog2(CURSOR_DEPTH + 1);
  // tail + alignment mask (up to 15 bits) + size, with headroom for the carries
  localparam int SUM_W  = ((OFF_W > 16) ? OFF_W : 16) + 2;
  localparam int MARK_W = PG_W + OFF_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_MARK    = 3'd2,
    CMD_RESTORE = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_DFREE      = 2'd1,
    ST_NO_PAGE    = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic need_pop;
  } dp_stat_t;

endpackage

// ----- sv/psa_chan_if.sv -----
interface psa_req_if import psa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SIZE_W-1:0]   size;
  logic [ALOG_W-1:0]   align_log2;
  logic [CIDX_W-1:0]   cursor_index;
  logic                cursor_present;

  modport source (output valid, cmd, size, align_log2, cursor_index, cursor_present,
                  input ready);
  modport sink   (input valid, cmd, size, align_log2, cursor_index, cursor_present,
                  output ready);
endinterface

interface psa_rsp_if import psa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  oversized;
  logic [PAGE_OUT_W-1:0] page_index;
  logic [OFFSET_W-1:0]   offset;
  logic [CIDX_W-1:0]     cursor_index_out;
  logic [LIVE_W-1:0]     live_cursors;

  modport source (output valid, status, oversized, page_index, offset, cursor_index_out,
                  live_cursors, input ready);
  modport sink   (input valid, status, oversized, page_index, offset, cursor_index_out,
                  live_cursors, output ready);
endinterface

// ----- sv/psa_ram.sv -----
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/psa_ctrl.sv -----
module psa_ctrl import psa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for room in the result register
        if (stat.out_free) begin
          ctl.exec   = 1'b1;
          state_next = stat.need_pop ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        ctl.pop    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/psa_datapath.sv -----
module psa_datapath import psa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              ctl,
  output dp_stat_t              stat,
  input  logic [CMD_W-1:0]      req_cmd,
  input  logic [SIZE_W-1:0]     req_size,
  input  logic [ALOG_W-1:0]     req_align_log2,
  input  logic [CIDX_W-1:0]     req_cursor_index,
  input  logic                  req_cursor_present,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [STATUS_W-1:0]   rsp_status,
  output logic                  rsp_oversized,
  output logic [PAGE_OUT_W-1:0] rsp_page_index,
  output logic [OFFSET_W-1:0]   rsp_offset,
  output logic [CIDX_W-1:0]     rsp_cursor_index_out,
  output logic [LIVE_W-1:0]     rsp_live_cursors
);

  localparam int CMPW = ((CNT_W > CIDX_W) ? CNT_W : CIDX_W) + 1;
  localparam int PGW1 = PCNT_W + 1;

  // latched request word
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [ALOG_W-1:0] alog_r;
  logic [CIDX_W-1:0] cidx_r;
  logic              present_r;

  // allocator state
  logic [PG_W-1:0]         tail_pg, tail_pg_next;
  logic [OFF_W-1:0]        tail_offset, tail_offset_next;
  logic [PCNT_W-1:0]       pages_made, pages_made_next;
  logic [CNT_W-1:0]        mark_depth, mark_depth_next;
  logic [CNT_W-1:0]        live_count, live_count_next;
  logic [BIG_W-1:0]        big_count, big_count_next;
  logic [CURSOR_DEPTH-1:0] mark_freed;

  // placement
  logic              first_page;
  logic [PG_W-1:0]   cur_page, new_page;
  logic [OFF_W-1:0]  cur_off, new_off, pl_size;
  logic [PCNT_W-1:0] pages_eff, new_pages;
  logic [ALOG_W-1:0] pl_alog;
  logic [SUM_W-1:0]  align_mask, start, nxt, place_start;
  logic              fits, reuse, grow, place_ok, do_place;

  // cursor stack
  logic              is_mark, oversized, stack_full, stale, is_top;
  logic [IDX_W-1:0]  mark_idx, cidx_i, pop_k;
  logic              mark_wr, freed_set, need_pop;
  logic [MARK_W-1:0] rd_data;
  logic [PG_W-1:0]   rd_page;
  logic [OFF_W-1:0]  rd_off;

  // result word
  logic [STATUS_W-1:0]   res_status;
  logic                  res_big;
  logic [PAGE_OUT_W-1:0] res_page;
  logic [OFFSET_W-1:0]   res_off;
  logic [CIDX_W-1:0]     res_cout;

  // saved tail per cursor
  psa_ram #(
    .WIDTH (MARK_W),
    .DEPTH (CURSOR_DEPTH)
  ) u_mark_ram (
    .clk   (clk),
    .we    (ctl.exec && mark_wr),
    .waddr (mark_idx),
    .wdata ({cur_page, cur_off}),
    .raddr (pop_k),
    .rdata (rd_data)
  );

  assign rd_page = rd_data[MARK_W-1:OFF_W];
  assign rd_off  = rd_data[OFF_W-1:0];

  // first use of the allocator creates page 0
  assign first_page = (pages_made == '0);
  assign cur_page   = first_page ? '0 : tail_pg;
  assign cur_off    = first_page ? '0 : tail_offset;
  assign pages_eff  = first_page ? PCNT_W'(1) : pages_made;

  assign is_mark    = (cmd_r == CMD_MARK);
  assign oversized  = (size_r > SIZE_W'(PAGE_BYTES));
  assign pl_size    = is_mark ? OFF_W'(CURSOR_RECORD_BYTES) : size_r[OFF_W-1:0];
  assign pl_alog    = is_mark ? ALOG_W'(CURSOR_ALIGN_LOG2) : alog_r;

  // round the tail up to the alignment, then try to fit the block
  assign align_mask = (SUM_W'(1) << pl_alog) - SUM_W'(1);
  assign start      = (SUM_W'(cur_off) + align_mask) & ~align_mask;
  assign nxt        = start + SUM_W'(pl_size);
  assign fits       = (nxt <= SUM_W'(PAGE_BYTES));
  assign reuse      = ((PGW1'(cur_page) + PGW1'(1)) < PGW1'(pages_eff));
  assign grow       = (pages_eff < PCNT_W'(MAX_PAGES));
  assign place_ok   = fits || reuse || grow;
  assign new_page   = fits ? cur_page : cur_page + PG_W'(1);
  assign new_off    = fits ? nxt[OFF_W-1:0] : pl_size;
  assign new_pages  = (!fits && !reuse) ? pages_eff + PCNT_W'(1) : pages_eff;
  assign place_start = fits ? start : '0;

  // cursor stack checks
  assign mark_idx   = mark_depth[IDX_W-1:0];
  assign cidx_i     = IDX_W'(cidx_r);
  assign stack_full = (mark_depth >= CNT_W'(CURSOR_DEPTH));
  assign stale      = (CMPW'(cidx_r) >= CMPW'(mark_depth)) || mark_freed[cidx_i];
  assign is_top     = ((CMPW'(cidx_r) + CMPW'(1)) == CMPW'(mark_depth));

  // new depth after a pop: one above the highest live cursor below the restored one
  always_comb begin
    pop_k = '0;
    for (int j = 0; j < CURSOR_DEPTH; j++) begin
      if ((IDX_W'(j) < cidx_i) && !mark_freed[j]) begin
        pop_k = IDX_W'(j + 1);
      end
    end
  end

  // command execution
  always_comb begin
    tail_pg_next     = tail_pg;
    tail_offset_next = tail_offset;
    pages_made_next  = pages_made;
    mark_depth_next  = mark_depth;
    live_count_next  = live_count;
    big_count_next   = big_count;
    do_place         = 1'b0;
    mark_wr          = 1'b0;
    freed_set        = 1'b0;
    need_pop         = 1'b0;
    res_status       = ST_OK;
    res_big          = 1'b0;
    res_page         = '0;
    res_off          = '0;
    res_cout         = '0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (oversized) begin
          res_big = 1'b1;
          if (big_count != '1) begin
            big_count_next = big_count + BIG_W'(1);
          end
        end else begin
          do_place = 1'b1;
          if (place_ok) begin
            res_page = PAGE_OUT_W'(new_page);
            res_off  = place_start[OFFSET_W-1:0];
          end else begin
            res_status = ST_NO_PAGE;
          end
        end
      end
      CMD_FREE: begin
        if (oversized) begin
          res_big = 1'b1;
          if (big_count == '0) begin
            res_status = ST_DFREE;
          end else begin
            big_count_next = big_count - BIG_W'(1);
          end
        end
      end
      CMD_MARK: begin
        if (stack_full) begin
          res_status = ST_STACK_FULL;
        end else begin
          do_place = 1'b1;
          if (place_ok) begin
            mark_wr         = 1'b1;
            res_cout        = CIDX_W'(mark_depth);
            mark_depth_next = mark_depth + CNT_W'(1);
            live_count_next = live_count + CNT_W'(1);
          end else begin
            res_status = ST_NO_PAGE;
          end
        end
      end
      CMD_RESTORE: begin
        if (present_r) begin
          if (stale) begin
            res_status = ST_DFREE;
          end else begin
            freed_set = 1'b1;
            if (live_count != '0) begin
              live_count_next = live_count - CNT_W'(1);
            end
            if (is_top) begin
              need_pop        = 1'b1;
              mark_depth_next = CNT_W'(pop_k);
            end
          end
        end
      end
      CMD_RESET: begin
        tail_pg_next     = '0;
        tail_offset_next = '0;
        mark_depth_next  = '0;
        live_count_next  = '0;
      end
      default: begin
      end
    endcase

    // a failed placement still keeps the first page it created
    if (do_place) begin
      tail_pg_next     = place_ok ? new_page : cur_page;
      tail_offset_next = place_ok ? new_off : cur_off;
      pages_made_next  = place_ok ? new_pages : pages_eff;
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;
  assign stat.need_pop = need_pop;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_pg     <= '0;
      tail_offset <= '0;
      pages_made  <= '0;
      mark_depth  <= '0;
      live_count  <= '0;
      big_count   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (ctl.exec) begin
        tail_pg     <= tail_pg_next;
        tail_offset <= tail_offset_next;
        pages_made  <= pages_made_next;
        mark_depth  <= mark_depth_next;
        live_count  <= live_count_next;
        big_count   <= big_count_next;
        rsp_valid   <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid   <= 1'b0;
      end
      // rewind to the saved tail read from the mark store
      if (ctl.pop) begin
        tail_pg     <= rd_page;
        tail_offset <= rd_off;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r     <= req_cmd;
      size_r    <= req_size;
      alog_r    <= req_align_log2;
      cidx_r    <= req_cursor_index;
      present_r <= req_cursor_present;
    end
    if (ctl.exec) begin
      if (mark_wr) begin
        mark_freed[mark_idx] <= 1'b0;
      end
      if (freed_set) begin
        mark_freed[cidx_i] <= 1'b1;
      end
      rsp_status           <= res_status;
      rsp_oversized        <= res_big;
      rsp_page_index       <= res_page;
      rsp_offset           <= res_off;
      rsp_cursor_index_out <= res_cout;
      rsp_live_cursors     <= LIVE_W'(live_count_next);
    end
  end

endmodule

// ----- sv/paged_stack_allocator_with_cursors.sv -----
// A word is latched into the payload registers in the idle state; the execute state
// then writes its result into the result register once that register is free. A
// restore that pops cursors adds a pop state, which takes the registered read of the
// saved tail from the mark RAM. One word is in flight at a time; the result register lets the next word in
// while a result waits. Reset (rst, synchronous) clears the tail, page count,
// cursor depth and counters; the mark RAM is not cleared and needs no sweep.
module paged_stack_allocator_with_cursors import psa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  psa_req_if.sink   req,
  psa_rsp_if.source rsp
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  psa_datapath u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .ctl                  (ctl),
    .stat                 (stat),
    .req_cmd              (req.cmd),
    .req_size             (req.size),
    .req_align_log2       (req.align_log2),
    .req_cursor_index     (req.cursor_index),
    .req_cursor_present   (req.cursor_present),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_oversized        (rsp.oversized),
    .rsp_page_index       (rsp.page_index),
    .rsp_offset           (rsp.offset),
    .rsp_cursor_index_out (rsp.cursor_index_out),
    .rsp_live_cursors     (rsp.live_cursors)
  );

endmodule

// ----- sv/psa_checker.sv -----
module psa_checker import psa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [STATUS_W-1:0]   status,
  input logic                  oversized,
  input logic [PAGE_OUT_W-1:0] page_index,
  input logic [OFFSET_W-1:0]   offset,
  input logic [CIDX_W-1:0]     cursor_index_out,
  input logic [LIVE_W-1:0]     live_cursors
);

  // result word holds while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({status, oversized, page_index, offset, cursor_index_out, live_cursors}))
    else $error("result word changed while stalled");

  // only one word in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // a failed command places nothing and makes no cursor
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |->
      page_index == '0 && offset == '0 && cursor_index_out == '0)
    else $error("failed command returned a placement");

  // oversized words are never placed
  a_big_unplaced: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && oversized |->
      page_index == '0 && offset == '0 && cursor_index_out == '0 &&
      (status == ST_OK || status == ST_DFREE))
    else $error("oversized word placed or bad status");

  // live cursor count bounded, no result right after reset
  a_live_bound: assert property (@(posedge clk)
    (rst |=> !rsp_valid) and
    (rsp_valid && !rst |-> live_cursors <= LIVE_W'(CURSOR_DEPTH)))
    else $error("live cursor count out of range or result after reset");

endmodule

bind paged_stack_allocator_with_cursors psa_checker u_psa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .status           (rsp.status),
  .oversized        (rsp.oversized),
  .page_index       (rsp.page_index),
  .offset           (rsp.offset),
  .cursor_index_out (rsp.cursor_index_out),
  .live_cursors     (rsp.live_cursors)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

import psa_pkg::*;

// One request word as driven on the request channel
typedef struct packed {
  logic [CMD_W-1:0]  cmd;
  logic [SIZE_W-1:0] size;
  logic [ALOG_W-1:0] align_log2;
  logic [CIDX_W-1:0] cursor_index;
  logic              cursor_present;
} req_word_t;

// One response word as seen on the response channel
typedef struct packed {
  logic [STATUS_W-1:0]   status;
  logic                  oversized;
  logic [PAGE_OUT_W-1:0] page_index;
  logic [OFFSET_W-1:0]   offset;
  logic [CIDX_W-1:0]     cursor_index_out;
  logic [LIVE_W-1:0]     live_cursors;
} rsp_word_t;

// Allocator shadow: tracks tail, pages and cursor stack, queues expected responses
class alloc_tracker;
  bit [PG_W-1:0]   tail_pg;
  bit [OFF_W-1:0]  tail_off;
  bit [PCNT_W-1:0] pages;
  bit [PG_W-1:0]   mk_pg[CURSOR_DEPTH];
  bit [OFF_W-1:0]  mk_off[CURSOR_DEPTH];
  bit              mk_freed[CURSOR_DEPTH];
  bit [CNT_W-1:0]  depth;
  bit [LIVE_W-1:0] live;
  bit [BIG_W-1:0]  big_cnt;
  rsp_word_t       pending_rsp[$];
  int              errors;

  function new();
    tail_pg  = '0;
    tail_off = '0;
    pages    = '0;
    depth    = '0;
    live     = '0;
    big_cnt  = '0;
    errors   = 0;
  endfunction

  task report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function void first_page();
    if (pages == 0) begin
      pages    = PCNT_W'(1);
      tail_pg  = '0;
      tail_off = '0;
    end
  endfunction

  // Bump-place a block of at most one page; spills to the next page if needed
  function status_t carve(input int unsigned sz, input int unsigned alog,
                          output logic [PG_W-1:0] pg, output logic [OFF_W-1:0] off);
    int unsigned a;
    int unsigned start;
    int unsigned nxt;
    pg  = '0;
    off = '0;
    a   = 1 << alog;
    first_page();
    start = (tail_off + a - 1) & ~(a - 1);
    nxt   = start + sz;
    if (nxt > PAGE_BYTES) begin
      if (tail_pg + 1 < pages) begin
        tail_pg++;
      end else if (pages < MAX_PAGES) begin
        pages++;
        tail_pg++;
      end else begin
        return ST_NO_PAGE;
      end
      start = 0;
      nxt   = sz;
    end
    tail_off = OFF_W'(nxt);
    pg  = tail_pg;
    off = OFF_W'(start);
    return ST_OK;
  endfunction

  function rsp_word_t predict_rsp(input req_word_t w);
    rsp_word_t        r;
    status_t          st;
    logic [PG_W-1:0]  p;
    logic [OFF_W-1:0] o;
    logic [PG_W-1:0]  sv_pg;
    logic [OFF_W-1:0] sv_off;
    int               k;
    r  = '0;
    st = ST_OK;
    case (w.cmd)
      CMD_ALLOC: begin
        if (w.size > PAGE_BYTES) begin
          r.oversized = 1'b1;
          if (big_cnt != 16'hFFFF) big_cnt++;
        end else begin
          st = carve(w.size, w.align_log2, p, o);
          if (st == ST_OK) begin
            r.page_index = p;
            r.offset     = o[OFFSET_W-1:0];
          end
        end
      end
      CMD_FREE: begin
        if (w.size > PAGE_BYTES) begin
          r.oversized = 1'b1;
          if (big_cnt == 0) st = ST_DFREE;
          else big_cnt--;
        end
      end
      CMD_MARK: begin
        if (depth >= CURSOR_DEPTH) begin
          st = ST_STACK_FULL;
        end else begin
          first_page();
          sv_pg  = tail_pg;
          sv_off = tail_off;
          st = carve(CURSOR_RECORD_BYTES, CURSOR_ALIGN_LOG2, p, o);
          if (st == ST_OK) begin
            mk_pg[depth]       = sv_pg;
            mk_off[depth]      = sv_off;
            mk_freed[depth]    = 1'b0;
            r.cursor_index_out = depth[CIDX_W-1:0];
            depth++;
            live++;
          end
        end
      end
      CMD_RESTORE: begin
        if (w.cursor_present) begin
          if (w.cursor_index >= depth || mk_freed[w.cursor_index]) begin
            st = ST_DFREE;
          end else begin
            mk_freed[w.cursor_index] = 1'b1;
            if (live > 0) live--;
            // topmost released: pop every freed cursor and rewind
            if (w.cursor_index + 1 == depth) begin
              k = int'(w.cursor_index);
              while (k > 0 && mk_freed[k-1]) k--;
              depth    = CNT_W'(k);
              tail_pg  = mk_pg[k];
              tail_off = mk_off[k];
            end
          end
        end
      end
      CMD_RESET: begin
        tail_pg  = '0;
        tail_off = '0;
        depth    = '0;
        live     = '0;
      end
      default: ;
    endcase
    r.status       = st;
    r.live_cursors = live;
    return r;
  endfunction

  function void log_request(input req_word_t w);
    pending_rsp.push_back(predict_rsp(w));
  endfunction

  task check_response(input rsp_word_t got);
    rsp_word_t exp;
    if (pending_rsp.size() == 0) begin
      report("response word with nothing pending");
    end else begin
      exp = pending_rsp.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.oversized !== exp.oversized)
        report($sformatf("oversized %0d, want %0d", got.oversized, exp.oversized));
      if (got.page_index !== exp.page_index)
        report($sformatf("page_index %0d, want %0d", got.page_index, exp.page_index));
      if (got.offset !== exp.offset)
        report($sformatf("offset %0d, want %0d", got.offset, exp.offset));
      if (got.cursor_index_out !== exp.cursor_index_out)
        report($sformatf("cursor_index_out %0d, want %0d",
                         got.cursor_index_out, exp.cursor_index_out));
      if (got.live_cursors !== exp.live_cursors)
        report($sformatf("live_cursors %0d, want %0d",
                         got.live_cursors, exp.live_cursors));
    end
  endtask
endclass

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 380;

  logic clk;
  logic rst;

  psa_req_if req_ch ();
  psa_rsp_if rsp_ch ();

  paged_stack_allocator_with_cursors i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alloc_tracker trk;
  int src_idle;
  int snk_stall;
  int words_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= snk_stall);
    end
  end

  // Response monitor
  always @(posedge clk) begin
    rsp_word_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
      got.status           = rsp_ch.status;
      got.oversized        = rsp_ch.oversized;
      got.page_index       = rsp_ch.page_index;
      got.offset           = rsp_ch.offset;
      got.cursor_index_out = rsp_ch.cursor_index_out;
      got.live_cursors     = rsp_ch.live_cursors;
      trk.check_response(got);
    end
  end

  // Watchdog: too long without any word moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drive one request word, with random idle cycles ahead of it
  task automatic send_word(input req_word_t w);
    while ($urandom_range(99) < src_idle) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.cmd            = w.cmd;
    req_ch.size           = w.size;
    req_ch.align_log2     = w.align_log2;
    req_ch.cursor_index   = w.cursor_index;
    req_ch.cursor_present = w.cursor_present;
    req_ch.valid          = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    trk.log_request(w);
    // unknown commands and null restores do nothing
    if (!(w.cmd > CMD_RESET || (w.cmd == CMD_RESTORE && !w.cursor_present)))
      words_sent++;
  endtask

  // Hold off the sender until every pending response is back
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (trk.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_word_t mk(input cmd_t c, input int unsigned sz,
                                   input int unsigned alog, input int unsigned idx,
                                   input bit pres);
    req_word_t w;
    w.cmd            = c;
    w.size           = SIZE_W'(sz);
    w.align_log2     = ALOG_W'(alog);
    w.cursor_index   = CIDX_W'(idx);
    w.cursor_present = pres;
    return w;
  endfunction

  function automatic req_word_t rand_fields();
    req_word_t w;
    w.cmd            = CMD_W'($urandom);
    w.size           = SIZE_W'($urandom);
    w.align_log2     = ALOG_W'($urandom);
    w.cursor_index   = CIDX_W'($urandom);
    w.cursor_present = 1'($urandom);
    return w;
  endfunction

  function automatic int unsigned rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 0;
    if (r < 55) return $urandom_range(1, 256);
    if (r < 80) return $urandom_range(257, PAGE_BYTES);
    if (r < 85) return $urandom_range(PAGE_BYTES, PAGE_BYTES + 1);
    return $urandom_range(PAGE_BYTES + 1, (1 << SIZE_W) - 1);
  endfunction

  function automatic int unsigned rand_align();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 12);
    return $urandom_range(13, 15);
  endfunction

  function automatic req_word_t alloc_word();
    req_word_t w;
    w = rand_fields();
    w.cmd        = CMD_ALLOC;
    w.size       = SIZE_W'(rand_size());
    w.align_log2 = ALOG_W'(rand_align());
    return w;
  endfunction

  function automatic req_word_t free_word();
    req_word_t w;
    w = rand_fields();
    w.cmd  = CMD_FREE;
    w.size = ($urandom_range(9) < 6) ? SIZE_W'($urandom_range(PAGE_BYTES + 1, (1 << SIZE_W) - 1))
                                     : SIZE_W'(rand_size());
    return w;
  endfunction

  function automatic req_word_t cmd_word(input cmd_t c);
    req_word_t w;
    w = rand_fields();
    w.cmd = c;
    return w;
  endfunction

  function automatic req_word_t restore_word(input int unsigned idx, input bit pres);
    req_word_t w;
    w = rand_fields();
    w.cmd            = CMD_RESTORE;
    w.cursor_index   = CIDX_W'(idx);
    w.cursor_present = pres;
    return w;
  endfunction

  // Weighted single command, restores mostly aimed at live stack positions
  function automatic req_word_t mixed_word();
    int r;
    int unsigned idx;
    r = $urandom_range(99);
    if (r < 40) return alloc_word();
    if (r < 52) return free_word();
    if (r < 70) return cmd_word(CMD_MARK);
    if (r < 92) begin
      if (trk.depth > 0 && $urandom_range(9) < 8) idx = $urandom_range(0, trk.depth - 1);
      else idx = $urandom_range(31);
      return restore_word(idx, $urandom_range(9) != 0);
    end
    if (r < 95) return cmd_word(CMD_RESET);
    return cmd_word(cmd_t'($urandom_range(5, 7)));
  endfunction

  // Nested marks with allocations, then release in LIFO or shuffled order
  task automatic cursor_episode();
    int n;
    int k;
    int j;
    int tmp;
    int order[$];
    n = $urandom_range(1, 36);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) < 3) send_word(alloc_word());
      send_word(cmd_word(CMD_MARK));
    end
    order.delete();
    for (k = trk.depth - 1; k >= 0; k--)
      if (!trk.mk_freed[k]) order.push_back(k);
    if ($urandom_range(1)) begin
      for (k = order.size() - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    for (k = 0; k < order.size(); k++) begin
      if ($urandom_range(9) == 0)
        send_word(restore_word($urandom_range(31), 1'($urandom_range(1))));
      send_word(restore_word(order[k], 1'b1));
    end
  endtask

  // Random traffic under one idle / stall setting
  task automatic run_phase(input int idle_pct, input int stall_pct);
    int r;
    int k;
    int n;
    src_idle   = idle_pct;
    snk_stall  = stall_pct;
    words_sent = 0;
    while (words_sent < PHASE_WORDS) begin
      r = $urandom_range(99);
      if (r < 45) begin
        n = $urandom_range(8, 30);
        for (k = 0; k < n; k++) send_word(mixed_word());
      end else if (r < 65) begin
        cursor_episode();
      end else if (r < 80) begin
        // fill pages with big blocks
        n = $urandom_range(6, 20);
        for (k = 0; k < n; k++)
          send_word(mk(CMD_ALLOC, $urandom_range(1024, PAGE_BYTES), $urandom_range(0, 12),
                       $urandom, 1'($urandom)));
      end else if (r < 85) begin
        send_word(cmd_word(CMD_RESET));
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) send_word(rand_fields());
      end
    end
    drain();
  endtask

  initial begin : main
    int k;
    trk        = new();
    src_idle   = 0;
    snk_stall  = 0;
    words_sent = 0;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.cmd            = '0;
    req_ch.size           = '0;
    req_ch.align_log2     = '0;
    req_ch.cursor_index   = '0;
    req_ch.cursor_present = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: edge sizes and alignments, every command, stale and null cursors
    send_word(mk(CMD_FREE, 0, 0, 0, 0));                   // small free, no page yet
    send_word(mk(CMD_FREE, PAGE_BYTES + 1, 0, 0, 0));      // oversized free with count 0
    send_word(mk(CMD_ALLOC, (1 << SIZE_W) - 1, 15, 31, 1)); // largest size
    send_word(mk(CMD_FREE, (1 << SIZE_W) - 1, 0, 0, 0));
    send_word(mk(CMD_ALLOC, 0, 0, 0, 0));                  // zero size, makes first page
    send_word(mk(CMD_ALLOC, 1, 0, 0, 0));
    send_word(mk(CMD_ALLOC, PAGE_BYTES, 12, 0, 0));        // full page, spills
    send_word(mk(CMD_ALLOC, 0, 0, 0, 0));                  // zero size at page end
    send_word(mk(CMD_ALLOC, 1, 15, 0, 0));                 // alignment above page
    send_word(mk(CMD_MARK, 0, 0, 0, 0));
    send_word(mk(CMD_ALLOC, 100, 4, 0, 0));
    send_word(mk(CMD_MARK, 0, 0, 0, 0));
    send_word(mk(CMD_RESTORE, 0, 0, 0, 1));                // not topmost
    send_word(mk(CMD_RESTORE, 0, 0, 0, 1));                // already freed
    send_word(mk(CMD_RESTORE, 0, 0, 31, 1));               // beyond depth
    send_word(mk(CMD_RESTORE, 0, 0, 1, 0));                // null cursor
    send_word(mk(CMD_RESTORE, 0, 0, 1, 1));                // pops both, rewinds
    send_word(mk(CMD_ALLOC, 8, 3, 0, 0));
    send_word(mk(cmd_t'(5), 0, 0, 0, 0));
    send_word(mk(cmd_t'(7), (1 << SIZE_W) - 1, 15, 31, 1));
    send_word(mk(CMD_MARK, 0, 0, 0, 0));
    send_word(mk(CMD_RESET, 0, 0, 0, 0));
    send_word(mk(CMD_ALLOC, 4, 2, 0, 0));
    drain();

    // Oversized counter: a run of big allocs, then frees one past the count
    for (k = 0; k < 24; k++)
      send_word(mk(CMD_ALLOC, $urandom_range(PAGE_BYTES + 1, (1 << SIZE_W) - 1),
                   $urandom, $urandom, 1'($urandom)));
    for (k = 0; k < 25; k++)
      send_word(mk(CMD_FREE, $urandom_range(PAGE_BYTES + 1, (1 << SIZE_W) - 1),
                   $urandom, $urandom, 1'($urandom)));
    drain();

    run_phase(0, 0);
    run_phase(83, 0);
    run_phase(0, 83);
    run_phase(28, 28);

    // Let any stray response show up
    repeat (20) @(posedge clk);
    if (trk.errors == 0 && trk.pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
